/* src/whbf_pkg.sv */
// Package with the shared constants, types and hash helpers of the word hash bitmap filter.
package whbf_pkg;

  localparam int CMD_W    = 2;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = 3;
  localparam int HASH_W   = 16;
  localparam int BUCKET_W = 13;

  localparam int TABLE_BITS_DEFAULT = 8191;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [WORD_W-1:0] HASH_SEED = 32'h811C_9DC5;
  localparam logic [WORD_W-1:0] HASH_MUL  = 32'h000A_D3E7;

  // Command codes carried on the input channel.
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    JOB_QUERY,
    JOB_INSERT,
    JOB_CLEAR
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [WORD_W-1:0] h_pre;
  } whbf_job_t;

  // Low 32 bits of a product with the hash multiplier.
  function automatic logic [WORD_W-1:0] hash_mul(input logic [WORD_W-1:0] a);
    logic [2*WORD_W-1:0] p;
    p = (2*WORD_W)'(a) * (2*WORD_W)'(HASH_MUL);
    return p[WORD_W-1:0];
  endfunction

endpackage

/* src/whbf_if.sv */
// Valid/ready channel interfaces for key words and for results.
interface whbf_in_if
  import whbf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  byte_count;
  logic              last;

  modport source (output valid, cmd, word, byte_count, last, input ready);
  modport sink   (input valid, cmd, word, byte_count, last, output ready);
endinterface

interface whbf_out_if
  import whbf_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [HASH_W-1:0]   hash_value;
  logic [BUCKET_W-1:0] bucket;
  logic                maybe_present;
  logic                cleared;

  modport source (output valid, hash_value, bucket, maybe_present, cleared, input ready);
  modport sink   (input valid, hash_value, bucket, maybe_present, cleared, output ready);
endinterface

/* src/whbf_queue.sv */
// Short FIFO of jobs between the front end and the back end.
module whbf_queue
  import whbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  whbf_job_t push_job,
  output logic      full,
  input  logic      pop,
  output whbf_job_t pop_job,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  whbf_job_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [PTR_W-1:0]    rptr;
  logic [CNT_QW-1:0]   count;

  assign full    = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/whbf_front.sv */
// Front end: takes key words, keeps the running hash and queues one job per finished key or clear.
module whbf_front
  import whbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  whbf_in_if.sink    words,
  input  logic       accept_en,
  input  logic       q_full,
  output logic       q_push,
  output whbf_job_t  q_job
);

  logic [WORD_W-1:0] running_hash;
  logic [WORD_W-1:0] held_word;
  logic              have_held;

  logic              accept;
  logic              is_key_cmd;
  logic              full_word;
  logic [WORD_W-1:0] tail_mask;
  logic [WORD_W-1:0] pair_key;
  logic [WORD_W-1:0] pair_val;
  logic [WORD_W-1:0] tail_val;

  assign words.ready = accept_en && !q_full;
  assign accept      = words.valid && words.ready;
  assign is_key_cmd  = (words.cmd == CMD_QUERY) || (words.cmd == CMD_INSERT);
  assign full_word   = (words.byte_count >= 3'd4);

  always_comb begin
    case (words.byte_count)
      3'd0:    tail_mask = 32'h0000_0000;
      3'd1:    tail_mask = 32'h0000_00FF;
      3'd2:    tail_mask = 32'h0000_FFFF;
      3'd3:    tail_mask = 32'h00FF_FFFF;
      default: tail_mask = 32'hFFFF_FFFF;
    endcase
  end

  // The one multiplier of the front end serves both mid-key pairs and a final full pair.
  assign pair_key = {held_word[WORD_W-6:0], held_word[WORD_W-1:WORD_W-5]} ^ words.word;
  assign pair_val = hash_mul(running_hash ^ pair_key);
  assign tail_val = running_hash ^ (have_held ? held_word : '0) ^ (words.word & tail_mask);

  assign q_push = accept && ((words.cmd == CMD_CLEAR) || (is_key_cmd && words.last));

  always_comb begin
    case (words.cmd)
      CMD_CLEAR:  q_job.kind = JOB_CLEAR;
      CMD_INSERT: q_job.kind = JOB_INSERT;
      default:    q_job.kind = JOB_QUERY;
    endcase
    q_job.h_pre = (have_held && full_word) ? pair_val : tail_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= HASH_SEED;
      held_word    <= '0;
      have_held    <= 1'b0;
    end else if (accept) begin
      case (words.cmd)
        CMD_QUERY, CMD_INSERT: begin
          if (words.last) begin
            running_hash <= HASH_SEED;
            held_word    <= '0;
            have_held    <= 1'b0;
          end else if (have_held) begin
            running_hash <= pair_val;
            held_word    <= '0;
            have_held    <= 1'b0;
          end else begin
            held_word <= words.word;
            have_held <= 1'b1;
          end
        end
        CMD_CLEAR: begin
          running_hash <= HASH_SEED;
          held_word    <= '0;
          have_held    <= 1'b0;
        end
        default: begin
          running_hash <= running_hash;
        end
      endcase
    end
  end

endmodule

/* src/whbf_back.sv */
// Back end: final multiply, fold, bucket reduction, bitmap lookup and update, and clearing sweeps.
module whbf_back
  import whbf_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  whbf_job_t  q_job,
  output logic       q_pop,
  output logic       bitmap_ready,
  whbf_out_if.source results
);

  localparam int AW = (TABLE_BITS > 1) ? $clog2(TABLE_BITS) : 1;
  // Reciprocal of the table size, scaled by 2^32, for the bucket reduction.
  localparam logic [WORD_W:0]    RECIP     = (WORD_W + 1)'((64'd1 << 32) / TABLE_BITS);
  localparam logic [HASH_W-1:0]  TB        = HASH_W'(TABLE_BITS);
  localparam logic [AW-1:0]      SWEEP_END = AW'(TABLE_BITS - 1);
  localparam int                 QP_W      = HASH_W + WORD_W + 1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL    = 8'b0000_0010,
    ST_QUOT   = 8'b0000_0100,
    ST_PROD   = 8'b0000_1000,
    ST_FIX    = 8'b0001_0000,
    ST_READ   = 8'b0010_0000,
    ST_RESULT = 8'b0100_0000,
    ST_SWEEP  = 8'b1000_0000
  } back_state_t;

  back_state_t       state;
  logic [WORD_W-1:0] h;
  logic [HASH_W-1:0] hv;
  logic [HASH_W-1:0] qe;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] rem;
  logic [AW-1:0]     sweep;
  logic              is_insert;
  logic              is_clear;
  logic              clr_ack;
  logic              rd_bit;
  logic              bitmap [TABLE_BITS];

  logic              res_valid;
  logic [HASH_W-1:0] res_hash;
  logic [BUCKET_W-1:0] res_bucket;
  logic              res_present;
  logic              res_cleared;

  logic [HASH_W-1:0] hv_c;
  logic [QP_W-1:0]   qprod;
  logic [HASH_W-1:0] diff;
  logic [HASH_W-1:0] rem_c;
  logic              load;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;

  assign hv_c  = h[HASH_W-1:0] ^ h[WORD_W-1:HASH_W];
  assign qprod = QP_W'(hv_c) * QP_W'(RECIP);
  // The estimated quotient is exact or one short, so one subtraction corrects it.
  assign diff  = hv - prod;
  assign rem_c = (diff >= TB) ? diff - TB : diff;

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign load      = (state == ST_RESULT) && (!res_valid || results.ready);
  assign mem_we    = (state == ST_SWEEP) || (load && is_insert && !is_clear);
  assign mem_waddr = (state == ST_SWEEP) ? sweep : rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_waddr] <= (state == ST_RESULT);
    end
    if (state == ST_READ) begin
      rd_bit <= bitmap[rem[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep        <= '0;
      clr_ack      <= 1'b0;
      is_clear     <= 1'b0;
      is_insert    <= 1'b0;
      bitmap_ready <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_job.kind == JOB_CLEAR) begin
              sweep   <= '0;
              clr_ack <= 1'b1;
              state   <= ST_SWEEP;
            end else begin
              is_insert <= (q_job.kind == JOB_INSERT);
              is_clear  <= 1'b0;
              state     <= ST_MUL;
            end
          end
        end
        ST_MUL:  state <= ST_QUOT;
        ST_QUOT: state <= ST_PROD;
        ST_PROD: state <= ST_FIX;
        ST_FIX:  state <= ST_READ;
        ST_READ: state <= ST_RESULT;
        ST_RESULT: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == SWEEP_END) begin
            bitmap_ready <= 1'b1;
            if (clr_ack) begin
              is_clear <= 1'b1;
              state    <= ST_RESULT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the hash and bucket stages.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: h    <= q_job.h_pre;
      ST_MUL:  h    <= hash_mul(h);
      ST_QUOT: begin
        hv <= hv_c;
        qe <= qprod[WORD_W+HASH_W-1:WORD_W];
      end
      ST_PROD: prod <= qe * TB;
      ST_FIX:  rem  <= rem_c;
      default: h    <= h;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_hash    <= is_clear ? '0 : hv;
      res_bucket  <= is_clear ? '0 : rem[BUCKET_W-1:0];
      res_present <= is_clear ? 1'b0 : rd_bit;
      res_cleared <= is_clear;
    end
  end

  assign results.valid         = res_valid;
  assign results.hash_value    = res_hash;
  assign results.bucket        = res_bucket;
  assign results.maybe_present = res_present;
  assign results.cleared       = res_cleared;

endmodule

/* src/word_hash_with_bitmap_filter.sv */
// Top level of the word hash bitmap filter: front end, job queue and back end.
//
// Keys arrive on the words channel as little-endian 32-bit words, one word per
// transfer, with last marking the final word; a clear command empties the bitmap.
// Each finished key or clear gives exactly one transfer on the results channel;
// words that are not last and command code three give none.
// A word that is not last is taken by the front end, which keeps the running
// hash with a single 32-bit multiplier. A finished key becomes a job in a
// two-entry queue; the back end works through it in steps (final multiply, fold,
// reciprocal quotient, product, remainder fix, bitmap read, result) and takes no
// new job until its result is loaded, while the front end takes the next key.
// A clear walks the one-bit bitmap memory one bit a cycle, then gives the
// cleared result.
// After reset the same sweep runs with no result, and words ready stays low
// until it is done.
// When the receiver stalls, the result register holds its transfer; the back end
// waits, the queue fills, and then words ready drops.
module word_hash_with_bitmap_filter
  import whbf_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  whbf_in_if.sink     words,
  whbf_out_if.source  results
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  logic      bitmap_ready;
  whbf_job_t push_job;
  whbf_job_t pop_job;

  // The front end accepts words only after the reset sweep and while the queue has room.
  whbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .words     (words),
    .accept_en (bitmap_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  whbf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // The back end owns the bitmap memory and the result register.
  whbf_back #(
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .bitmap_ready (bitmap_ready),
    .results      (results)
  );

endmodule

/* src/whbf_checker.sv */
// Port-level checks of the word hash bitmap filter and their binding to the top level.
module whbf_checker
  import whbf_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEFAULT
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [HASH_W-1:0]   hash_value,
  input logic [BUCKET_W-1:0] bucket,
  input logic                maybe_present,
  input logic                cleared
);

  // A stalled result keeps its transfer unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(hash_value) && $stable(bucket)
      && $stable(maybe_present) && $stable(cleared))
    else $error("stalled result changed");

  // A clear acknowledgement carries all-zero fields.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && cleared |-> hash_value == '0 && bucket == '0 && !maybe_present)
    else $error("clear result has nonzero fields");

  // The bucket is the folded hash reduced by the table size.
  a_bucket: assert property (@(posedge clk) disable iff (rst)
    res_valid && !cleared |-> bucket == BUCKET_W'(hash_value % TABLE_BITS))
    else $error("bucket does not match hash value");

  // Reset empties the result register and holds off input at the start of the sweep.
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind word_hash_with_bitmap_filter whbf_checker #(
  .TABLE_BITS (TABLE_BITS)
) u_whbf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (words.ready),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .hash_value    (results.hash_value),
  .bucket        (results.bucket),
  .maybe_present (results.maybe_present),
  .cleared       (results.cleared)
);
